// ----- hw/rtl/ebp_pkg.sv -----
`timescale 1ns / 1ps

package ebp_pkg;

  // Reserved grouping ids with placement rules.
  localparam logic [6:0] GID_START = 7'd126;
  localparam logic [6:0] GID_END   = 7'd127;

  // Result kinds.
  localparam logic KIND_GROUP   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One input byte of a private-data record.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result item: a grouping id or a record summary.
  typedef struct packed {
    logic        kind;
    logic [6:0]  group_id;
    logic [7:0]  flag_bits;
    logic [2:0]  sap_type;
    logic [63:0] acquire_time;
    logic [7:0]  partition_count;
    logic        groups_ok;
    logic        truncated;
    logic        last;
  } res_t;

  // Results produced by one accepted byte, handed to the result queue.
  typedef struct packed {
    logic [1:0] push_cnt;
    res_t       res_a;
    res_t       res_b;
  } push_t;

endpackage

// ----- hw/rtl/ebp_parse_core.sv -----
`timescale 1ns / 1ps

module ebp_parse_core import ebp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_take,
  input  in_t   in_item,
  output push_t push
);

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_FLAG  = 7'b0000001,
    PH_EXT   = 7'b0000010,
    PH_SAP   = 7'b0000100,
    PH_GROUP = 7'b0001000,
    PH_TIME  = 7'b0010000,
    PH_PART  = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  // Next present field after phase p, given the current flags.
  function automatic phase_t advance(input phase_t p, input logic [7:0] flags);
    logic [4:0] above;
    logic [4:0] cand;
    phase_t     q;
    case (p)
      PH_FLAG:  above = 5'b11111;
      PH_EXT:   above = 5'b11110;
      PH_SAP:   above = 5'b11100;
      PH_GROUP: above = 5'b11000;
      PH_TIME:  above = 5'b10000;
      default:  above = 5'b00000;
    endcase
    // Bit order: extension, SAP, grouping, time, partition.
    cand = {flags[0], flags[3], flags[4], flags[5], flags[1]} & above;
    if (cand[0]) begin
      q = PH_EXT;
    end else if (cand[1]) begin
      q = PH_SAP;
    end else if (cand[2]) begin
      q = PH_GROUP;
    end else if (cand[3]) begin
      q = PH_TIME;
    end else if (cand[4]) begin
      q = PH_PART;
    end else begin
      q = PH_DONE;
    end
    return q;
  endfunction

  phase_t       phase_r, phase_nxt;
  logic [7:0]   flag_r, flag_nxt;
  logic [2:0]   sap_r, sap_nxt;
  logic [63:0]  time_r, time_nxt;
  logic [3:0]   left_r, left_nxt;
  logic [7:0]   part_r, part_nxt;
  logic [127:0] seen_r, seen_nxt;
  logic [6:0]   prev_r, prev_nxt;
  logic         have_prev_r, have_prev_nxt;
  logic         bad_r, bad_nxt;

  logic [7:0]   b;
  logic [6:0]   id;
  logic         time_done;
  res_t         gid_res;
  res_t         sum_res;

  assign b  = in_item.data_byte;
  assign id = b[6:0];

  // Parse one byte and build the results it causes.
  always_comb begin
    phase_nxt     = phase_r;
    flag_nxt      = flag_r;
    sap_nxt       = sap_r;
    time_nxt      = time_r;
    left_nxt      = left_r;
    part_nxt      = part_r;
    seen_nxt      = seen_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    bad_nxt       = bad_r;
    gid_res       = '0;
    sum_res       = '0;
    push          = '0;

    case (phase_r)
      PH_FLAG: begin
        // Reserved bit 1 is dropped; bit 0 becomes the extension flag.
        flag_nxt  = {b[7:2], b[0], 1'b0};
        phase_nxt = advance(PH_FLAG, flag_nxt);
      end
      PH_EXT: begin
        flag_nxt  = {flag_r[7:1], flag_r[0] | b[7]};
        phase_nxt = advance(PH_EXT, flag_nxt);
      end
      PH_SAP: begin
        sap_nxt   = b[7:5];
        phase_nxt = advance(PH_SAP, flag_r);
      end
      PH_GROUP: begin
        if (seen_r[id]) begin
          bad_nxt = 1'b1;
        end
        if (id == GID_START &&
            (!have_prev_r || prev_r == GID_START || prev_r == GID_END)) begin
          bad_nxt = 1'b1;
        end
        if (id == GID_END && (!have_prev_r || prev_r == GID_END)) begin
          bad_nxt = 1'b1;
        end
        seen_nxt[id]  = 1'b1;
        prev_nxt      = id;
        have_prev_nxt = 1'b1;
        gid_res.kind     = KIND_GROUP;
        gid_res.group_id = id;
        gid_res.last     = !in_item.last_byte;
        // The top bit chains another grouping id.
        if (!b[7]) begin
          phase_nxt = advance(PH_GROUP, flag_r);
        end
      end
      PH_TIME: begin
        time_nxt = {time_r[55:0], b};
        if (left_r != 4'd0) begin
          left_nxt = left_r - 4'd1;
        end
        if (left_nxt == 4'd0) begin
          phase_nxt = advance(PH_TIME, flag_r);
        end
      end
      PH_PART: begin
        part_nxt  = b;
        phase_nxt = advance(PH_PART, flag_r);
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // Entering the time field loads the byte count.
    if (phase_nxt == PH_TIME && phase_r != PH_TIME) begin
      left_nxt = 4'd8;
    end

    // Summary on the record's last byte.
    time_done = flag_nxt[3] && (phase_nxt == PH_PART || phase_nxt == PH_DONE);
    sum_res.kind            = KIND_SUMMARY;
    sum_res.flag_bits       = flag_nxt;
    sum_res.sap_type        = sap_nxt;
    sum_res.acquire_time    = time_done ? time_nxt : 64'd0;
    sum_res.partition_count = part_nxt;
    sum_res.groups_ok       = !bad_nxt;
    sum_res.truncated       = (phase_nxt != PH_DONE);
    sum_res.last            = 1'b1;

    // Hand the results to the queue.
    if (in_take) begin
      if (phase_r == PH_GROUP) begin
        push.res_a = gid_res;
        push.res_b = sum_res;
        push.push_cnt = in_item.last_byte ? 2'd2 : 2'd1;
      end else if (in_item.last_byte) begin
        push.res_a = sum_res;
        push.push_cnt = 2'd1;
      end
    end

    // The record ends: start clean for the next flag byte.
    if (in_item.last_byte) begin
      phase_nxt     = PH_FLAG;
      flag_nxt      = '0;
      sap_nxt       = '0;
      time_nxt      = '0;
      left_nxt      = '0;
      part_nxt      = '0;
      seen_nxt      = '0;
      prev_nxt      = '0;
      have_prev_nxt = 1'b0;
      bad_nxt       = 1'b0;
    end
  end

  // Record state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAG;
      flag_r      <= '0;
      sap_r       <= '0;
      time_r      <= '0;
      left_r      <= '0;
      part_r      <= '0;
      seen_r      <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      bad_r       <= 1'b0;
    end else if (in_take) begin
      phase_r     <= phase_nxt;
      flag_r      <= flag_nxt;
      sap_r       <= sap_nxt;
      time_r      <= time_nxt;
      left_r      <= left_nxt;
      part_r      <= part_nxt;
      seen_r      <= seen_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      bad_r       <= bad_nxt;
    end
  end

endmodule

// ----- hw/rtl/ebp_result_queue.sv -----
`timescale 1ns / 1ps

module ebp_result_queue import ebp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_data
);

  localparam int Depth = 4;

  res_t       mem_r [Depth];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  // Input is accepted only while at least two entries are free for the next transfer.
  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;

  // Pointer and fill count updates.
  always_comb begin
    wr_nxt  = wr_r + push.push_cnt;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.push_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage: the first result at the write pointer, the second after it.
  always_ff @(posedge clk) begin
    if (push.push_cnt != 2'd0) begin
      mem_r[wr_r] <= push.res_a;
    end
    if (push.push_cnt == 2'd2) begin
      mem_r[wr_r + 2'd1] <= push.res_b;
    end
  end

endmodule

// ----- hw/rtl/ebp_private_data_parser.sv -----
`timescale 1ns / 1ps

// Encoder boundary point private-data parser. Record bytes arrive one per
// transfer, first byte first, with last_byte set on the record's final byte.
// Each grouping id is reported as a kind 0 result when its byte is taken, and
// the final byte adds a kind 1 summary (flags, SAP type, acquisition time,
// partition count, grouping-rule check, truncation flag); last marks the final
// result of a transfer. A byte is parsed in the cycle it is taken and its
// results are written into a four-entry result queue, so one byte is accepted
// every cycle while in_ready is high; its results are registered in the queue
// before the output. in_ready drops only while the queue holds more than two
// results, which happens only when the result side stalls; a byte that ends a
// record inside the grouping ids produces two results, and the queue absorbs
// them without blocking input while the result side takes one every cycle.
module ebp_private_data_parser import ebp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic  in_take;
  logic  room;
  push_t push;

  assign in_ready = room;
  assign in_take  = in_valid && in_ready;

  // Byte parser and record state.
  ebp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_item (in_data),
    .push    (push)
  );

  // Result queue toward the output channel.
  ebp_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb_ebp_private_data_parser.sv -----
`timescale 1ns / 1ps

module tb_ebp_private_data_parser;
  import ebp_pkg::*;

  // Parser stages of a record, in stream order.
  typedef enum logic [3:0] {
    ST_FLAG  = 4'd0,
    ST_EXT   = 4'd1,
    ST_SAP   = 4'd2,
    ST_GROUP = 4'd3,
    ST_TIME  = 4'd4,
    ST_PART  = 4'd5,
    ST_DONE  = 4'd6
  } stage_t;

  // Positions in the decoded flag byte.
  localparam int FB_PART  = 0;
  localparam int FB_EXT   = 1;
  localparam int FB_TIME  = 3;
  localparam int FB_GROUP = 4;
  localparam int FB_SAP   = 5;

  localparam int TIME_BYTES   = 8;
  localparam int IDLE_PCT     = 28;
  localparam int STALL_CYCLES = 80;
  localparam int HANG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_COUNT   = 750;
  localparam int REPORT_MAX   = 10;

  // Record mixes for the random part.
  localparam int MIX_CLEAN  = 0;
  localparam int MIX_BROKEN = 1;
  localparam int MIX_NOISE  = 2;

  // One stimulus row; want is used only where typed is set.
  typedef struct {
    in_t  item;
    logic typed;
    res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;

  // Mirror of the parser state for one record.
  stage_t       rec_stage = ST_FLAG;
  logic [7:0]   rec_flags = '0;
  logic [2:0]   rec_sap = '0;
  logic [63:0]  rec_time = '0;
  logic [3:0]   rec_time_left = '0;
  logic [7:0]   rec_parts = '0;
  logic [127:0] rec_seen = '0;
  logic [6:0]   rec_prev = '0;
  logic         rec_have_prev = 1'b0;
  logic         rec_bad = 1'b0;

  res_t      pending_results[$];
  stim_row_t offered_rows[$];
  stim_row_t directed_rows[$];

  int bad_results = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  ebp_private_data_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Start a new record in the mirror.
  function automatic void clear_record();
    rec_stage = ST_FLAG;
    rec_flags = '0;
    rec_sap = '0;
    rec_time = '0;
    rec_time_left = '0;
    rec_parts = '0;
    rec_seen = '0;
    rec_prev = '0;
    rec_have_prev = 1'b0;
    rec_bad = 1'b0;
  endfunction

  function automatic logic stage_present(input stage_t s);
    case (s)
      ST_EXT:   return rec_flags[FB_EXT];
      ST_SAP:   return rec_flags[FB_SAP];
      ST_GROUP: return rec_flags[FB_GROUP];
      ST_TIME:  return rec_flags[FB_TIME];
      ST_PART:  return rec_flags[FB_PART];
      default:  return 1'b0;
    endcase
  endfunction

  // Move to the next announced field after the given stage.
  function automatic void next_stage(input stage_t from);
    for (int q = int'(from) + 1; q < int'(ST_DONE); q++) begin
      if (stage_present(stage_t'(q))) begin
        rec_stage = stage_t'(q);
        if (rec_stage == ST_TIME) begin
          rec_time_left = 4'(TIME_BYTES);
        end
        return;
      end
    end
    rec_stage = ST_DONE;
  endfunction

  // Parse one record byte and queue the grouping id and summary it yields.
  function automatic void parse_record_byte(input in_t item);
    logic [7:0] b;
    logic [6:0] id;
    res_t       r;
    b = item.data_byte;
    case (rec_stage)
      ST_FLAG: begin
        // The extension flag travels in bit 0; the reserved bit 1 is dropped.
        rec_flags = {b[7:2], b[0], 1'b0};
        next_stage(ST_FLAG);
      end
      ST_EXT: begin
        rec_flags[FB_PART] = rec_flags[FB_PART] | b[7];
        next_stage(ST_EXT);
      end
      ST_SAP: begin
        rec_sap = b[7:5];
        next_stage(ST_SAP);
      end
      ST_GROUP: begin
        id = b[6:0];
        if (rec_seen[id]) begin
          rec_bad = 1'b1;
        end
        if (id == GID_START &&
            (!rec_have_prev || rec_prev == GID_START || rec_prev == GID_END)) begin
          rec_bad = 1'b1;
        end
        if (id == GID_END && (!rec_have_prev || rec_prev == GID_END)) begin
          rec_bad = 1'b1;
        end
        rec_seen[id] = 1'b1;
        rec_prev = id;
        rec_have_prev = 1'b1;
        r = '0;
        r.kind = KIND_GROUP;
        r.group_id = id;
        r.last = !item.last_byte;
        pending_results.push_back(r);
        // A clear top bit ends the chain of grouping ids.
        if (!b[7]) begin
          next_stage(ST_GROUP);
        end
      end
      ST_TIME: begin
        rec_time = {rec_time[55:0], b};
        if (rec_time_left > 0) begin
          rec_time_left = rec_time_left - 4'd1;
        end
        if (rec_time_left == 0) begin
          next_stage(ST_TIME);
        end
      end
      ST_PART: begin
        rec_parts = b;
        next_stage(ST_PART);
      end
      default: begin
        rec_stage = ST_DONE;
      end
    endcase

    // The final byte closes the record with a summary.
    if (item.last_byte) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.flag_bits = rec_flags;
      r.sap_type = rec_sap;
      r.acquire_time = (rec_flags[FB_TIME] && rec_stage > ST_TIME) ? rec_time : 64'd0;
      r.partition_count = rec_parts;
      r.groups_ok = !rec_bad;
      r.truncated = (rec_stage != ST_DONE);
      r.last = 1'b1;
      pending_results.push_back(r);
      clear_record();
    end
  endfunction

  // A summary with all optional field values zero and clean grouping.
  function automatic res_t bare_summary(input logic [7:0] flags, input logic trunc);
    res_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.flag_bits = flags;
    r.groups_ok = 1'b1;
    r.truncated = trunc;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic lb,
                                  input logic typed, input res_t want);
    stim_row_t row;
    row.item.data_byte = b;
    row.item.last_byte = lb;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Offer one byte and hold it until the parser takes it.
  task automatic send_row(input stim_row_t row);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= row.item;
    offered_rows.push_back(row);
    do begin
      @(posedge clk);
    end while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [6:0] pick_group_id();
    case ($urandom_range(3))
      0:       return GID_START;
      1:       return GID_END;
      2:       return 7'($urandom_range(7));
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  // Build one record (well formed, cut short, or plain noise) and send it.
  task automatic send_record(input int mix);
    in_t        bytes[$];
    in_t        one;
    stim_row_t  row;
    logic [7:0] flags;
    logic [7:0] ext;
    int         n_ids;
    int         cut;
    if (mix == MIX_NOISE) begin
      repeat ($urandom_range(1, 6)) begin
        one.data_byte = 8'($urandom);
        one.last_byte = ($urandom_range(3) == 0);
        bytes.push_back(one);
      end
    end else begin
      one.last_byte = 1'b0;
      flags = 8'($urandom);
      ext = 8'($urandom);
      one.data_byte = flags;
      bytes.push_back(one);
      if (flags[0]) begin
        one.data_byte = ext;
        bytes.push_back(one);
      end
      if (flags[FB_SAP]) begin
        one.data_byte = 8'($urandom);
        bytes.push_back(one);
      end
      if (flags[FB_GROUP]) begin
        n_ids = $urandom_range(1, 5);
        for (int i = 0; i < n_ids; i++) begin
          one.data_byte = {(i != n_ids - 1), pick_group_id()};
          bytes.push_back(one);
        end
      end
      if (flags[FB_TIME]) begin
        repeat (TIME_BYTES) begin
          one.data_byte = 8'($urandom);
          bytes.push_back(one);
        end
      end
      if (flags[0] && ext[7]) begin
        one.data_byte = 8'($urandom);
        bytes.push_back(one);
      end
      // Trailing bytes past the announced fields.
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          one.data_byte = 8'($urandom);
          bytes.push_back(one);
        end
      end
      if (mix == MIX_BROKEN) begin
        cut = $urandom_range(1, bytes.size());
        bytes = bytes[0:cut-1];
      end
      bytes[bytes.size()-1].last_byte = 1'b1;
    end
    foreach (bytes[i]) begin
      row.item = bytes[i];
      row.typed = 1'b0;
      row.want = '0;
      send_row(row);
    end
  endtask

  // Predict on every input transfer, check every output transfer, pace the
  // result side and watch for a hang.
  always @(posedge clk) begin : monitor
    stim_row_t row;
    res_t      want;
    logic      differs;
    if (in_valid && in_ready) begin
      row = offered_rows.pop_front();
      parse_record_byte(in_data);
      if (row.typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(row.want);
      end
    end

    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_MAX) begin
          $display("%0t: unexpected result %p", $realtime, out_data);
        end
      end else begin
        want = pending_results.pop_front();
        differs = (out_data.kind !== want.kind) ||
                  (out_data.group_id !== want.group_id) ||
                  (out_data.flag_bits !== want.flag_bits) ||
                  (out_data.sap_type !== want.sap_type) ||
                  (out_data.acquire_time !== want.acquire_time) ||
                  (out_data.partition_count !== want.partition_count) ||
                  (out_data.groups_ok !== want.groups_ok) ||
                  (out_data.truncated !== want.truncated) ||
                  (out_data.last !== want.last);
        if (differs) begin
          bad_results++;
          if (bad_results <= REPORT_MAX) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %p", want);
            $display("  actual   %p", out_data);
          end
        end
      end
    end

    // A requested long stall makes the result queue fill and block input.
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
    end

    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int   mix_pick;
    res_t none;
    none = '0;
    clear_record();

    // Lone flag bytes, a full record at the extremes, a grouping rule break,
    // a partial acquisition time, trailing bytes and an extension without
    // the partition flag.
    add_row(8'h00, 1'b1, 1'b1, bare_summary(8'h00, 1'b0));
    add_row(8'hFF, 1'b1, 1'b1, bare_summary(8'hFE, 1'b1));
    add_row(8'hFF, 1'b0, 1'b0, none);
    add_row(8'h80, 1'b0, 1'b0, none);
    add_row(8'hE0, 1'b0, 1'b0, none);
    add_row(8'h81, 1'b0, 1'b0, none);
    add_row(8'hFE, 1'b0, 1'b0, none);
    add_row(8'h7F, 1'b0, 1'b0, none);
    repeat (TIME_BYTES) add_row(8'hFF, 1'b0, 1'b0, none);
    add_row(8'hFF, 1'b1, 1'b0, none);
    add_row(8'h10, 1'b0, 1'b0, none);
    add_row(8'hFE, 1'b0, 1'b0, none);
    add_row(8'h05, 1'b1, 1'b0, none);
    add_row(8'h08, 1'b0, 1'b0, none);
    add_row(8'h12, 1'b0, 1'b0, none);
    add_row(8'h34, 1'b1, 1'b1, bare_summary(8'h08, 1'b1));
    add_row(8'h00, 1'b0, 1'b0, none);
    add_row(8'hAA, 1'b0, 1'b0, none);
    add_row(8'h55, 1'b1, 1'b1, bare_summary(8'h00, 1'b0));
    add_row(8'h01, 1'b0, 1'b0, none);
    add_row(8'h00, 1'b1, 1'b1, bare_summary(8'h02, 1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_row(directed_rows[i]);
    end

    // Random records; the first stretch runs with no idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (items_sent < ITEM_COUNT) begin
      if (items_sent > 200) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      if (items_sent > 350 && items_sent <= 360) begin
        hold_req = 1'b1;
      end
      mix_pick = $urandom_range(99);
      if (mix_pick < 70) begin
        send_record(MIX_CLEAN);
      end else if (mix_pick < 90) begin
        send_record(MIX_BROKEN);
      end else begin
        send_record(MIX_NOISE);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- ebp_private_data_parser.f -----
hw/rtl/ebp_pkg.sv
hw/rtl/ebp_parse_core.sv
hw/rtl/ebp_result_queue.sv
hw/rtl/ebp_private_data_parser.sv
tb/tb_ebp_private_data_parser.sv
